>>> hdl/hue_mask_cleanup_window_locator_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hue mask cleanup window locator
// Concurrent property wrappers shared by the files that assert.
// ----------------------------------------------------------------------------
`ifndef HUE_MASK_CLEANUP_WINDOW_LOCATOR_MACROS_SVH
`define HUE_MASK_CLEANUP_WINDOW_LOCATOR_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define HMCWL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define HMCWL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HMCWL_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define HMCWL_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

>>> hdl/hmcwl_pkg.sv
// ----------------------------------------------------------------------------
// Hue mask cleanup window locator package
// Frame geometry, widths, state codes and control bundles.
// ----------------------------------------------------------------------------
package hmcwl_pkg;

    localparam int FRAME_ROWS    = 62;
    localparam int FRAME_COLS    = 82;
    localparam int INNER_ROWS    = FRAME_ROWS - 2;
    localparam int INNER_COLS    = FRAME_COLS - 2;
    localparam int INNER_PIXELS  = INNER_ROWS * INNER_COLS;
    localparam int WINDOW_COUNT  = 5;
    localparam int WINDOW_WIDTH  = 16;
    localparam int HUE_REGS      = 4;

    localparam int ROW_W   = 6;   // frame row 0..61, also word bit index
    localparam int COL_W   = 7;   // frame column 0..81, also mask column address
    localparam int BIT_W   = 6;   // bit index inside one column word
    localparam int COUNT_W = 13;
    localparam int TALLY_W = 10;
    localparam int WIN_W   = 3;
    localparam int HUE_W   = 8;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // last centre column address of a cleanup pass and last centre row bit
    localparam int LAST_CENTRE = INNER_COLS - 2;
    localparam int LAST_ROWBIT = INNER_ROWS - 2;
    localparam int FILL_MIN    = 5;   // pass one fills at this many hit neighbours
    localparam int KEEP_MIN    = 5;   // pass two keeps a hit at this many

    typedef logic [INNER_ROWS-1:0] t_word;

    typedef enum logic [3:0] {
        S_INPUT,
        S_PRIME,
        S_SHIFT,
        S_ROWS,
        S_WB,
        S_TREAD,
        S_TLOAD,
        S_TBITS,
        S_PICK
    } t_state;

    typedef struct packed {
        logic             shift;
        logic             update;
        logic             pass;
        logic [BIT_W-1:0] row;
    } t_clean_ctrl;

    typedef struct packed {
        logic             clear;
        logic             load;
        logic             count;
        logic [WIN_W-1:0] win;
    } t_tally_ctrl;

endpackage

>>> hdl/hmcwl_mask_ram.sv
// ----------------------------------------------------------------------------
// Hit mask memory
// One column word per address, bit-masked write port, registered read port.
// ----------------------------------------------------------------------------
module hmcwl_mask_ram (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [hmcwl_pkg::COL_W-1:0] i_waddr,
    input  hmcwl_pkg::t_word          i_wmask,
    input  hmcwl_pkg::t_word          i_wdata,
    input  logic                      i_re,
    input  logic [hmcwl_pkg::COL_W-1:0] i_raddr,
    output hmcwl_pkg::t_word          o_rdata
);
    import hmcwl_pkg::*;

    t_word r_mem [INNER_COLS];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            for (int b = 0; b < INNER_ROWS; b++) begin
                if (i_wmask[b]) begin
                    r_mem[i_waddr][b] <= i_wdata[b];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/hmcwl_cleaner.sv
// ----------------------------------------------------------------------------
// Column cleaner
// Three-column window; applies fill or prune to one centre bit per cycle.
// ----------------------------------------------------------------------------
module hmcwl_cleaner (
    input  logic                   i_clk,
    input  hmcwl_pkg::t_clean_ctrl i_ctrl,
    input  hmcwl_pkg::t_word       i_rdata,
    output hmcwl_pkg::t_word       o_centre
);
    import hmcwl_pkg::*;

    t_word            r_left;
    t_word            r_centre;
    t_word            r_right;
    logic [BIT_W-1:0] k_up;
    logic [BIT_W-1:0] k_dn;
    logic [3:0]       nbr;
    logic             busy_nbr;
    logic             n_bit;

    always_comb begin
        k_up = i_ctrl.row - BIT_W'(1);
        k_dn = i_ctrl.row + BIT_W'(1);
        nbr  = {3'b0, r_left[k_up]}   + {3'b0, r_left[i_ctrl.row]}  + {3'b0, r_left[k_dn]}
             + {3'b0, r_centre[k_up]} + {3'b0, r_centre[k_dn]}
             + {3'b0, r_right[k_up]}  + {3'b0, r_right[i_ctrl.row]} + {3'b0, r_right[k_dn]};
        busy_nbr = (nbr >= 4'(FILL_MIN));
        // pass one fills, pass two prunes
        if (i_ctrl.pass) begin
            n_bit = r_centre[i_ctrl.row] & (nbr >= 4'(KEEP_MIN));
        end else begin
            n_bit = r_centre[i_ctrl.row] | busy_nbr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_left   <= r_centre;
            r_centre <= r_right;
            r_right  <= i_rdata;
        end else if (i_ctrl.update) begin
            r_centre[i_ctrl.row] <= n_bit;
        end
    end

    assign o_centre = r_centre;

endmodule

>>> hdl/hmcwl_tally.sv
// ----------------------------------------------------------------------------
// Window tally
// Bit-serial count of hits per 16-column window and the leading window.
// ----------------------------------------------------------------------------
module hmcwl_tally (
    input  logic                        i_clk,
    input  hmcwl_pkg::t_tally_ctrl      i_ctrl,
    input  hmcwl_pkg::t_word            i_rdata,
    output logic [hmcwl_pkg::COUNT_W-1:0] o_total,
    output logic [hmcwl_pkg::WIN_W-1:0]   o_best
);
    import hmcwl_pkg::*;

    t_word              r_shift;
    logic [TALLY_W-1:0] r_win [WINDOW_COUNT];
    logic [COUNT_W-1:0] r_total;
    logic [TALLY_W-1:0] best_val;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.clear) begin
            r_total <= '0;
            for (int w = 0; w < WINDOW_COUNT; w++) begin
                r_win[w] <= '0;
            end
        end else if (i_ctrl.count) begin
            r_total <= r_total + COUNT_W'(r_shift[0]);
            for (int w = 0; w < WINDOW_COUNT; w++) begin
                if (i_ctrl.win == WIN_W'(w)) begin
                    r_win[w] <= r_win[w] + TALLY_W'(r_shift[0]);
                end
            end
        end
        if (i_ctrl.load) begin
            r_shift <= i_rdata;
        end else if (i_ctrl.count) begin
            r_shift <= r_shift >> 1;
        end
    end

    // lowest index wins ties
    always_comb begin
        best_val = r_win[0];
        o_best   = '0;
        for (int w = 1; w < WINDOW_COUNT; w++) begin
            if (best_val < r_win[w]) begin
                best_val = r_win[w];
                o_best   = WIN_W'(w);
            end
        end
    end

    assign o_total = r_total;

endmodule

>>> hdl/hue_mask_cleanup_window_locator.sv
// ----------------------------------------------------------------------------
// Hue mask cleanup window locator
// Builds a hit mask from one frame of hues, cleans it and finds the busiest
// 16-column window.
// ----------------------------------------------------------------------------
// A frame is 62 rows of 82 pixels in raster order, one request per pixel on
// the slave stream, taken at one pixel per cycle. Inner pixels are hits when
// the hue is flagged valid and its bit is set in the 256-bit hue set written
// through the configuration port; border pixels are taken but ignored. The
// mask is held in a column-organised memory (80 words of 60 bits, one read
// and one masked write per cycle, registered read data). After the last
// pixel the slave side drops tready while the mask is worked on: two cleanup
// passes that each stream a three-column window through the cleaner, one
// centre row per cycle, then a bit-serial tally of all 80 columns and a pick
// of the window, which waits for the output register to be free. A frame
// gives one result request on the master stream. The result sits in an
// output register, so the next frame is taken while it waits; the memory
// needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "hue_mask_cleanup_window_locator_macros.svh"

module hue_mask_cleanup_window_locator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  logic [hmcwl_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [hmcwl_pkg::CFG_W-1:0]       i_cfg_wdata,
    // pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] pixel_hue, [8] hue_valid, [15:9] zero
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [12:0] match_count, [25:13] miss_count,
                                        // [28:26] target_window, [31:29] zero
);
    import hmcwl_pkg::*;

    t_state             r_state, n_state;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [COL_W-1:0]   r_col, n_col;
    logic               r_pass, n_pass;
    logic               r_rd_pend, n_rd_pend;
    logic [CFG_W-1:0]   r_hue_set [HUE_REGS];

    logic               r_out_valid;
    logic [COUNT_W-1:0] r_match;
    logic [COUNT_W-1:0] r_miss;
    logic [WIN_W-1:0]   r_window;

    logic [HUE_W-1:0]   pixel_hue;
    logic               hue_valid;
    logic               accept;
    logic               inner;
    logic               hit;
    logic               out_load;

    logic               ram_we;
    logic [COL_W-1:0]   ram_waddr;
    t_word              ram_wmask;
    t_word              ram_wdata;
    logic               ram_re;
    logic [COL_W-1:0]   ram_raddr;
    t_word              ram_rdata;
    t_word              centre;

    t_clean_ctrl        clean_ctrl;
    t_tally_ctrl        tally_ctrl;
    logic [COUNT_W-1:0] total;
    logic [WIN_W-1:0]   best;

    assign pixel_hue = s_axis_tdata[HUE_W-1:0];
    assign hue_valid = s_axis_tdata[HUE_W];
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign inner     = (r_row != '0) && (r_row != ROW_W'(FRAME_ROWS - 1))
                    && (r_col != '0) && (r_col != COL_W'(FRAME_COLS - 1));
    assign hit       = hue_valid && r_hue_set[pixel_hue[7:6]][pixel_hue[5:0]];

    // hue set registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HUE_REGS; i++) begin
                r_hue_set[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_hue_set[i_cfg_index] <= i_cfg_wdata;
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INPUT;
            r_row     <= '0;
            r_col     <= '0;
            r_pass    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_row     <= n_row;
            r_col     <= n_col;
            r_pass    <= n_pass;
            r_rd_pend <= n_rd_pend;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_col      = r_col;
        n_pass     = r_pass;
        n_rd_pend  = 1'b0;
        s_axis_tready = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_col;
        ram_wmask  = '1;
        ram_wdata  = centre;
        ram_re     = 1'b0;
        ram_raddr  = r_col;
        out_load   = 1'b0;
        clean_ctrl = '{shift: r_rd_pend, update: 1'b0, pass: r_pass, row: r_row};
        tally_ctrl = '{clear: 1'b0, load: 1'b0, count: 1'b0, win: r_col[6:4]};

        case (r_state)
            S_INPUT: begin
                s_axis_tready = 1'b1;
                if (accept) begin
                    // store an inner pixel at its column word, row bit
                    if (inner) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_col - COL_W'(1);
                        ram_wmask = t_word'(1) << (r_row - ROW_W'(1));
                        ram_wdata = {INNER_ROWS{hit}};
                    end
                    if (r_col == COL_W'(FRAME_COLS - 1)) begin
                        n_col = '0;
                        if (r_row == ROW_W'(FRAME_ROWS - 1)) begin
                            n_row   = '0;
                            n_pass  = 1'b0;
                            n_state = S_PRIME;
                        end else begin
                            n_row = r_row + ROW_W'(1);
                        end
                    end else begin
                        n_col = r_col + COL_W'(1);
                    end
                end
            end
            S_PRIME: begin
                // fetch the first three columns into the window
                ram_re    = 1'b1;
                ram_raddr = COL_W'(r_row);
                n_rd_pend = 1'b1;
                if (r_row == ROW_W'(2)) begin
                    n_col   = COL_W'(1);
                    n_state = S_SHIFT;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            S_SHIFT: begin
                n_row   = ROW_W'(1);
                n_state = S_ROWS;
            end
            S_ROWS: begin
                clean_ctrl.update = 1'b1;
                if (r_row == ROW_W'(LAST_ROWBIT)) begin
                    n_state = S_WB;
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            S_WB: begin
                // write back the finished centre column, fetch the next right one
                ram_we = 1'b1;
                if (r_col == COL_W'(LAST_CENTRE)) begin
                    n_row = '0;
                    if (!r_pass) begin
                        n_pass  = 1'b1;
                        n_state = S_PRIME;
                    end else begin
                        n_col            = '0;
                        tally_ctrl.clear = 1'b1;
                        n_state          = S_TREAD;
                    end
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = r_col + COL_W'(2);
                    n_rd_pend = 1'b1;
                    n_col     = r_col + COL_W'(1);
                    n_state   = S_SHIFT;
                end
            end
            S_TREAD: begin
                ram_re  = 1'b1;
                n_state = S_TLOAD;
            end
            S_TLOAD: begin
                tally_ctrl.load = 1'b1;
                n_row           = '0;
                n_state         = S_TBITS;
            end
            S_TBITS: begin
                tally_ctrl.count = 1'b1;
                if (r_row == ROW_W'(INNER_ROWS - 1)) begin
                    if (r_col == COL_W'(INNER_COLS - 1)) begin
                        n_state = S_PICK;
                    end else begin
                        n_col   = r_col + COL_W'(1);
                        n_state = S_TREAD;
                    end
                end else begin
                    n_row = r_row + ROW_W'(1);
                end
            end
            S_PICK: begin
                // hold until the output register is free
                if (!r_out_valid || m_axis_tready) begin
                    out_load = 1'b1;
                    n_row    = '0;
                    n_col    = '0;
                    n_state  = S_INPUT;
                end
            end
            default: begin
                n_state = S_INPUT;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_match  <= total;
            r_miss   <= COUNT_W'(INNER_PIXELS) - total;
            r_window <= best;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_window, r_miss, r_match};

    hmcwl_mask_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wmask (ram_wmask),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hmcwl_cleaner u_cleaner (
        .i_clk    (i_clk),
        .i_ctrl   (clean_ctrl),
        .i_rdata  (ram_rdata),
        .o_centre (centre)
    );

    hmcwl_tally u_tally (
        .i_clk   (i_clk),
        .i_ctrl  (tally_ctrl),
        .i_rdata (ram_rdata),
        .o_total (total),
        .o_best  (best)
    );

    // a result appears only out of the pick step
    `HMCWL_ASSERT_NEXT(a_result_from_pick, i_clk, i_rst_n, !m_axis_tvalid && r_state != S_PICK, !m_axis_tvalid, "result raised outside pick")
    // cleanup write-back stays within the processed columns
    `HMCWL_ASSERT_IMPL(a_wb_column, i_clk, i_rst_n, r_state == S_WB, r_col >= COL_W'(1) && r_col <= COL_W'(LAST_CENTRE), "write-back column out of range")
    // every inner pixel is either a hit or a miss
    `HMCWL_ASSERT_IMPL(a_counts_sum, i_clk, i_rst_n, m_axis_tvalid, (r_match + r_miss) == COUNT_W'(INNER_PIXELS), "hit and miss counts disagree")
    // a window shift never coincides with a row update
    `HMCWL_ASSERT_IMPL(a_shift_idle, i_clk, i_rst_n, r_rd_pend, r_state == S_PRIME || r_state == S_SHIFT, "window shift during row update")

endmodule

>>> tb/hue_mask_cleanup_window_locator_tb.sv
// ----------------------------------------------------------------------------
// Hue mask cleanup window locator testbench
// Streams whole frames of hues into the block and checks the per-frame
// hit count, miss count and busiest window. Expected results come from a
// behavioural copy of the mask, its two cleanup passes and the window pick.
// A short scripted set of frames covers the corner cases, then random frames
// follow with random hue sets, hit regions and densities, random idling on
// both streams and one long result-side hold-off.
// ----------------------------------------------------------------------------
module hue_mask_cleanup_window_locator_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hmcwl_pkg::*;

    localparam int FRAME_PIXELS  = FRAME_ROWS * FRAME_COLS;
    localparam int FILL_AT       = 5;      // pass one fills a miss at this many hit neighbours
    localparam int CLEAR_AT      = 4;      // pass two clears a hit at this many or fewer
    localparam int N_SCRIPT      = 12;
    localparam int RANDOM_FRAMES = 24;
    localparam int HOLD_CYCLES   = 60000;  // longer than a whole frame plus its cleanup
    localparam int SETTLE        = 32;
    localparam int RUN_LIMIT     =
        4 * ((N_SCRIPT + RANDOM_FRAMES) * (FRAME_PIXELS * 15 + 15000) + HOLD_CYCLES);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUE_0_63,
        REG_HUE_64_127,
        REG_HUE_128_191,
        REG_HUE_192_255
    } t_hue_reg;

    // how the pixels of one frame are painted
    typedef enum {
        ART_UNDEFINED,   // every hue flagged invalid
        ART_FLAT,        // one hue everywhere
        ART_BORDER,      // valid hues on the border only
        ART_RAMP,        // hue runs through all 256 values
        ART_BAND,        // valid hues in a column band only
        ART_CHECKER,
        ART_HOLES,       // solid hits with single-pixel holes
        ART_SPECKLE      // random hits, denser inside a rectangle
    } t_frame_art;

    typedef struct packed {
        logic        valid;
        logic [7:0]  hue;
    } t_pixel;

    // laid out as the result tdata, match_count in the lowest bits
    typedef struct packed {
        logic [WIN_W-1:0]   target_window;
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] match_count;
    } t_window_report;

    typedef struct {
        logic [HUE_REGS*CFG_W-1:0] hues;
        t_frame_art                art;
        logic [7:0]                hue_arg;
        int                        col_lo, col_hi, row_lo, row_hi;
        int                        pct_in, pct_out;
        bit                        typed;
        t_window_report            want;
    } t_frame_plan;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata = '0;   // [7:0] pixel_hue, [8] hue_valid, [15:9] zero
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [31:0]           m_axis_tdata;        // [12:0] match_count, [25:13] miss_count,
                                                // [28:26] target_window, [31:29] zero

    // mirror of the block's state
    logic [CFG_W-1:0]  hue_bank [HUE_REGS];
    bit                pixel_mask [FRAME_ROWS][FRAME_COLS];
    int                raster_pos;
    int                hit_total;

    t_window_report    expected_reports [$];
    logic [7:0]        member_hues [$];
    logic [7:0]        other_hues [$];
    t_frame_plan       script [N_SCRIPT];
    int                faults = 0;
    int                reports_taken = 0;
    int                cycles_run = 0;

    hue_mask_cleanup_window_locator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // watchdog: a hung block or a lost result ends the run here
    always @(posedge i_clk) begin
        cycles_run <= cycles_run + 1;
        if (cycles_run == RUN_LIMIT) begin
            $display("%0t: run limit of %0d cycles reached", $time, RUN_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic int hits_around(int r, int c);
        int sum;
        sum = 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (dr != 0 || dc != 0)
                    sum += pixel_mask[r + dr][c + dc];
        return sum;
    endfunction

    // Both passes walk column-major over the cleanable interior; a change is
    // seen straight away by the pixels visited after it.
    function automatic void tidy_mask();
        for (int c = 2; c < FRAME_COLS - 2; c++)
            for (int r = 2; r < FRAME_ROWS - 2; r++)
                if (!pixel_mask[r][c] && hits_around(r, c) >= FILL_AT) begin
                    pixel_mask[r][c] = 1'b1;
                    hit_total++;
                end
        for (int c = 2; c < FRAME_COLS - 2; c++)
            for (int r = 2; r < FRAME_ROWS - 2; r++)
                if (pixel_mask[r][c] && hits_around(r, c) <= CLEAR_AT) begin
                    pixel_mask[r][c] = 1'b0;
                    hit_total--;
                end
    endfunction

    // lowest window index wins a tie
    function automatic logic [WIN_W-1:0] busiest_window();
        int tally [WINDOW_COUNT];
        int best;
        best = 0;
        for (int w = 0; w < WINDOW_COUNT; w++) begin
            tally[w] = 0;
            for (int c = 1 + WINDOW_WIDTH * w; c < 1 + WINDOW_WIDTH * (w + 1); c++)
                for (int r = 1; r < FRAME_ROWS - 1; r++)
                    tally[w] += pixel_mask[r][c];
        end
        for (int w = 1; w < WINDOW_COUNT; w++)
            if (tally[best] < tally[w])
                best = w;
        return WIN_W'(best);
    endfunction

    // Take one pixel; returns 1 with the frame report on the last pixel.
    function automatic bit absorb_pixel(input logic [7:0] hue, input logic valid,
                                        output t_window_report rep);
        int r;
        int c;
        bit hit;
        rep = '0;
        if (raster_pos == 0)
            hit_total = 0;
        r = raster_pos / FRAME_COLS;
        c = raster_pos % FRAME_COLS;
        // border pixels only advance the position
        if (r >= 1 && r < FRAME_ROWS - 1 && c >= 1 && c < FRAME_COLS - 1) begin
            hit = valid && hue_bank[hue[7:6]][hue[5:0]];
            pixel_mask[r][c] = hit;
            hit_total += hit;
        end
        raster_pos++;
        if (raster_pos < FRAME_PIXELS)
            return 1'b0;
        raster_pos = 0;
        tidy_mask();
        rep.match_count   = COUNT_W'(hit_total);
        rep.miss_count    = COUNT_W'(INNER_PIXELS - hit_total);
        rep.target_window = busiest_window();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Frame plans and pixel painting
    // ------------------------------------------------------------------------

    function automatic t_frame_plan frame_plan(logic [HUE_REGS*CFG_W-1:0] hues,
                                               t_frame_art art, logic [7:0] hue_arg,
                                               int col_lo, int col_hi, bit typed,
                                               int hits, int misses, int win);
        t_frame_plan plan;
        plan.hues    = hues;
        plan.art     = art;
        plan.hue_arg = hue_arg;
        plan.col_lo  = col_lo;
        plan.col_hi  = col_hi;
        plan.row_lo  = 0;
        plan.row_hi  = FRAME_ROWS - 1;
        plan.pct_in  = 0;
        plan.pct_out = 0;
        plan.typed   = typed;
        plan.want.match_count   = COUNT_W'(hits);
        plan.want.miss_count    = COUNT_W'(misses);
        plan.want.target_window = WIN_W'(win);
        return plan;
    endfunction

    function automatic logic [HUE_REGS*CFG_W-1:0] random_hue_set();
        logic [HUE_REGS*CFG_W-1:0] hues;
        for (int i = 0; i < HUE_REGS; i++)
            case ($urandom_range(0, 4))
                0:       hues[CFG_W*i +: CFG_W] = '0;
                1:       hues[CFG_W*i +: CFG_W] = '1;
                2:       hues[CFG_W*i +: CFG_W] = 64'd1 << $urandom_range(0, CFG_W - 1);
                default: hues[CFG_W*i +: CFG_W] = {$urandom, $urandom};
            endcase
        return hues;
    endfunction

    function automatic t_frame_plan random_plan();
        t_frame_plan plan;
        int w;
        plan = frame_plan('0, ART_SPECKLE, 8'd0, 0, 0, 1'b0, 0, 0, 0);
        // a third of the time line the dense region up with whole windows
        if ($urandom_range(0, 2) == 0) begin
            w = $urandom_range(0, WINDOW_COUNT - 1);
            plan.col_lo = 1 + WINDOW_WIDTH * w;
            plan.col_hi = plan.col_lo + WINDOW_WIDTH * $urandom_range(1, WINDOW_COUNT - w) - 1;
        end else begin
            plan.col_lo = $urandom_range(0, FRAME_COLS - 1);
            plan.col_hi = $urandom_range(plan.col_lo, FRAME_COLS - 1);
        end
        plan.row_lo  = $urandom_range(0, FRAME_ROWS - 1);
        plan.row_hi  = $urandom_range(plan.row_lo, FRAME_ROWS - 1);
        plan.pct_in  = $urandom_range(40, 100);
        plan.pct_out = $urandom_range(0, 45);
        return plan;
    endfunction

    function automatic t_pixel paint_pixel(t_frame_plan plan, int r, int c);
        t_pixel px;
        bit     rim;
        bit     want_hit;
        rim = (r == 0 || r == FRAME_ROWS - 1 || c == 0 || c == FRAME_COLS - 1);
        px.hue   = plan.hue_arg;
        px.valid = 1'b1;
        case (plan.art)
            ART_UNDEFINED: begin
                px.valid = 1'b0;
                px.hue   = 8'($urandom);
            end
            ART_FLAT: ;
            ART_BORDER:  px.valid = rim;
            ART_RAMP:    px.hue = 8'(r * FRAME_COLS + c);
            ART_BAND: begin
                if (c < plan.col_lo || c > plan.col_hi) begin
                    px.valid = 1'b0;
                    px.hue   = 8'($urandom);
                end
            end
            ART_CHECKER: px.valid = 1'((r + c) % 2);
            ART_HOLES:   px.valid = !(r % 4 == 2 && c % 4 == 2);
            default: begin
                want_hit = $urandom_range(0, 99) <
                    ((r >= plan.row_lo && r <= plan.row_hi &&
                      c >= plan.col_lo && c <= plan.col_hi) ? plan.pct_in : plan.pct_out);
                if (want_hit && member_hues.size() != 0) begin
                    px.hue = member_hues[$urandom_range(0, member_hues.size() - 1)];
                end else if (other_hues.size() == 0 || $urandom_range(0, 3) == 0) begin
                    // a hue with no valid flag, whatever its bits
                    px.valid = 1'b0;
                    px.hue   = 8'($urandom);
                end else begin
                    px.hue = other_hues[$urandom_range(0, other_hues.size() - 1)];
                end
            end
        endcase
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Pixel stream and configuration drivers
    // ------------------------------------------------------------------------

    // Offer one pixel request after an optional idle gap and hold it until
    // taken. tvalid stays high between back-to-back requests.
    task automatic offer_pixel(input t_pixel px, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, px.valid, px.hue};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic load_hue_set(input logic [HUE_REGS*CFG_W-1:0] hues);
        t_hue_reg id;
        id = id.first();
        do begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= id;
            i_cfg_wdata <= hues[CFG_W*id +: CFG_W];
            hue_bank[id] = hues[CFG_W*id +: CFG_W];
            @(posedge i_clk);
            id = id.next();
        end while (id != id.first());
        i_cfg_we <= 1'b0;
    endtask

    // Let every outstanding report drain, settle, then rewrite the hue set.
    task automatic retune(input logic [HUE_REGS*CFG_W-1:0] hues);
        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        load_hue_set(hues);
    endtask

    task automatic play_frame(input t_frame_plan plan);
        t_pixel         px;
        t_window_report rep;
        int             gap_odds;
        int             gap;
        // split the current hue set so painting can aim for hits or misses
        member_hues.delete();
        other_hues.delete();
        for (int h = 0; h < 256; h++)
            if (hue_bank[h / 64][h % 64])
                member_hues.push_back(8'(h));
            else
                other_hues.push_back(8'(h));
        // idle pattern for this frame: none, rare gaps or frequent gaps
        case ($urandom_range(0, 3))
            0:       gap_odds = 0;
            3:       gap_odds = 4;
            default: gap_odds = 64;
        endcase
        for (int r = 0; r < FRAME_ROWS; r++)
            for (int c = 0; c < FRAME_COLS; c++) begin
                px  = paint_pixel(plan, r, c);
                gap = (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) ?
                      $urandom_range(0, 14) : 0;
                offer_pixel(px, gap);
                if (absorb_pixel(px.hue, px.valid, rep))
                    expected_reports.push_back(plan.typed ? plan.want : rep);
            end
    endtask

    // ------------------------------------------------------------------------
    // Result sink: random stalls, one long hold-off, field-by-field check
    // ------------------------------------------------------------------------

    initial begin : result_sink
        int             stall;
        t_window_report got;
        t_window_report want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 14);
            // hold off on the first random frame's report so the next frames
            // pile up behind it and the pixel stream gets stalled
            if (reports_taken == N_SCRIPT)
                stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                do @(posedge i_clk); while (!m_axis_tvalid);
                repeat (stall - 1) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            reports_taken++;
            got = m_axis_tdata[$bits(t_window_report)-1:0];
            if (expected_reports.size() == 0) begin
                $display("%0t: unexpected report, expected none, got %h",
                         $time, m_axis_tdata);
                faults++;
            end else begin
                want = expected_reports.pop_front();
                if (got.match_count != want.match_count) begin
                    $display("%0t: match_count expected %0d got %0d",
                             $time, want.match_count, got.match_count);
                    faults++;
                end
                if (got.miss_count != want.miss_count) begin
                    $display("%0t: miss_count expected %0d got %0d",
                             $time, want.miss_count, got.miss_count);
                    faults++;
                end
                if (got.target_window != want.target_window) begin
                    $display("%0t: target_window expected %0d got %0d",
                             $time, want.target_window, got.target_window);
                    faults++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin : stimulus
        int phase_left;
        phase_left = 0;
        for (int i = 0; i < HUE_REGS; i++)
            hue_bank[i] = '0;
        foreach (pixel_mask[r, c])
            pixel_mask[r][c] = 1'b0;
        raster_pos = 0;
        hit_total  = 0;

        // scripted frames; counts typed in only where they are plain
        script[0]  = frame_plan('0, ART_UNDEFINED, 8'd0, 0, 0, 1'b1, 0, INNER_PIXELS, 0);
        script[1]  = frame_plan('1, ART_FLAT, 8'd255, 0, 0, 1'b1, INNER_PIXELS, 0, 0);
        script[2]  = frame_plan('1, ART_UNDEFINED, 8'd0, 0, 0, 1'b1, 0, INNER_PIXELS, 0);
        script[3]  = frame_plan('1, ART_BORDER, 8'd0, 0, 0, 1'b1, 0, INNER_PIXELS, 0);
        // lowest and highest hue each alone in the set
        script[4]  = frame_plan(256'd1, ART_FLAT, 8'd0, 0, 0, 1'b1, INNER_PIXELS, 0, 0);
        script[5]  = frame_plan({1'b1, 255'd0}, ART_FLAT, 8'd0, 0, 0, 1'b1,
                                0, INNER_PIXELS, 0);
        script[6]  = frame_plan({1'b1, 255'd0}, ART_FLAT, 8'd255, 0, 0, 1'b1,
                                INNER_PIXELS, 0, 0);
        script[7]  = frame_plan({64'hF0F0_F0F0_F0F0_F0F0, 64'h0F0F_0F0F_0F0F_0F0F,
                                 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555},
                                ART_RAMP, 8'd0, 0, 0, 1'b0, 0, 0, 0);
        // two equal windows: the lower one must win
        script[8]  = frame_plan('1, ART_BAND, 8'd17, 33, 64, 1'b0, 0, 0, 0);
        script[9]  = frame_plan('1, ART_BAND, 8'd200, 65, 80, 1'b0, 0, 0, 0);
        script[10] = frame_plan('1, ART_CHECKER, 8'd99, 0, 0, 1'b0, 0, 0, 0);
        script[11] = frame_plan('1, ART_HOLES, 8'd128, 0, 0, 1'b0, 0, 0, 0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k]) begin
            retune(script[k].hues);
            play_frame(script[k]);
        end

        // random frames in phases; frames within a phase run back to back
        for (int f = 0; f < RANDOM_FRAMES; f++) begin
            if (phase_left == 0) begin
                phase_left = (f == 0) ? 5 : $urandom_range(1, 4);
                retune(random_hue_set());
            end
            play_frame(random_plan());
            phase_left--;
        end

        s_axis_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
